@@ design/csfr_pkg.sv @@
// ----------------------------------------------------------------------------
// CO2 sensor frame receiver package
// Shared types and constants for the frame parser and its output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csfr_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] RegChangeThreshold = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGapTimeout      = 8'd1;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic [7:0] FrameStart = 8'hFF;
  localparam logic [7:0] FrameCmd   = 8'h86;
  localparam logic [7:0] SumBase    = 8'hFF;

  localparam logic [3:0] IdxStart   = 4'd0;
  localparam logic [3:0] IdxCmd     = 4'd1;
  localparam logic [3:0] IdxPpmHigh = 4'd2;
  localparam logic [3:0] IdxPpmLow  = 4'd3;
  localparam logic [3:0] IdxLast    = 4'd8;

  localparam logic [15:0] ThresholdReset = 16'd1;
  localparam logic [15:0] TimeoutReset   = 16'd10;
  localparam logic [15:0] TimerMax       = 16'hFFFF;

  typedef struct packed {
    logic [15:0] change_threshold;
    logic [15:0] gap_timeout_ticks;
  } csfr_cfg_t;

  typedef struct packed {
    logic [15:0] ppm;
    logic        significant_change;
  } csfr_result_t;

endpackage

`default_nettype wire

@@ design/csfr_parser.sv @@
// ----------------------------------------------------------------------------
// CO2 sensor frame parser
// Gathers nine-byte response frames, checks header and checksum, handles the
// inter-byte gap timeout and flags significant ppm changes.
// ----------------------------------------------------------------------------
`default_nettype none

module csfr_parser (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire csfr_pkg::csfr_cfg_t   cfg_i,
  input  wire logic                  item_valid_i,
  input  wire logic                  cmd_i,
  input  wire logic [7:0]            rx_byte_i,
  output logic                       res_valid_o,
  output csfr_pkg::csfr_result_t     res_o
);
  import csfr_pkg::*;

  logic [3:0]  byte_index_q, byte_index_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic        header_good_q, header_good_d;
  logic [7:0]  ppm_high_q, ppm_high_d;
  logic [7:0]  ppm_low_q, ppm_low_d;
  logic [15:0] gap_timer_q, gap_timer_d;
  logic [15:0] last_ppm_q, last_ppm_d;

  logic [15:0] ppm;
  logic [15:0] diff;
  logic        sig;
  logic [15:0] gap_next;
  logic        frame_ok;

  assign ppm      = {ppm_high_q, ppm_low_q};
  assign diff     = (ppm >= last_ppm_q) ? (ppm - last_ppm_q) : (last_ppm_q - ppm);
  assign sig      = (diff >= cfg_i.change_threshold);
  assign gap_next = (gap_timer_q == TimerMax) ? gap_timer_q : (gap_timer_q + 16'd1);
  assign frame_ok = header_good_q && (rx_byte_i == (SumBase - running_sum_q));

  always_comb begin
    byte_index_d  = byte_index_q;
    running_sum_d = running_sum_q;
    header_good_d = header_good_q;
    ppm_high_d    = ppm_high_q;
    ppm_low_d     = ppm_low_q;
    gap_timer_d   = gap_timer_q;
    last_ppm_d    = last_ppm_q;
    res_valid_o   = 1'b0;
    res_o.ppm                = ppm;
    res_o.significant_change = sig;

    if (item_valid_i) begin
      if (cmd_i == CmdTick) begin
        if (byte_index_q != IdxStart) begin
          gap_timer_d = gap_next;
          if (gap_next >= cfg_i.gap_timeout_ticks) begin
            byte_index_d  = IdxStart;
            running_sum_d = 8'd0;
            header_good_d = 1'b0;
            gap_timer_d   = 16'd0;
          end
        end
      end else begin
        gap_timer_d = 16'd0;
        if (byte_index_q < IdxLast) begin
          case (byte_index_q)
            IdxStart:   header_good_d = (rx_byte_i == FrameStart);
            IdxCmd:     header_good_d = header_good_q && (rx_byte_i == FrameCmd);
            IdxPpmHigh: ppm_high_d    = rx_byte_i;
            IdxPpmLow:  ppm_low_d     = rx_byte_i;
            default: ;
          endcase
          running_sum_d = running_sum_q + rx_byte_i;
          byte_index_d  = byte_index_q + 4'd1;
        end else begin
          byte_index_d  = IdxStart;
          running_sum_d = 8'd0;
          header_good_d = 1'b0;
          if (frame_ok) begin
            res_valid_o = 1'b1;
            if (sig) begin
              last_ppm_d = ppm;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= IdxStart;
      running_sum_q <= 8'd0;
      header_good_q <= 1'b0;
      ppm_high_q    <= 8'd0;
      ppm_low_q     <= 8'd0;
      gap_timer_q   <= 16'd0;
      last_ppm_q    <= 16'd0;
    end else begin
      byte_index_q  <= byte_index_d;
      running_sum_q <= running_sum_d;
      header_good_q <= header_good_d;
      ppm_high_q    <= ppm_high_d;
      ppm_low_q     <= ppm_low_d;
      gap_timer_q   <= gap_timer_d;
      last_ppm_q    <= last_ppm_d;
    end
  end

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q <= IdxLast)
    else $error("frame byte index out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (item_valid_i && cmd_i == CmdByte && byte_index_q == IdxLast
                     && header_good_q))
    else $error("result without a complete good frame");

  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_index_q == IdxStart) |-> (gap_timer_q == 16'd0))
    else $error("gap timer running while idle");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && cmd_i == CmdTick && byte_index_q == IdxStart)
    |=> (byte_index_q == IdxStart))
    else $error("tick while idle changed frame state");
`endif

endmodule

`default_nettype wire

@@ design/csfr_out_fifo.sv @@
// ----------------------------------------------------------------------------
// CO2 sensor frame receiver output queue
// Two-entry result queue so the parser keeps taking requests while one
// result waits for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module csfr_out_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire csfr_pkg::csfr_result_t data_i,
  output logic                       full_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output csfr_pkg::csfr_result_t     data_o
);
  import csfr_pkg::*;

  csfr_result_t mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign data_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

@@ design/co2_sensor_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// CO2 sensor frame receiver
// Parses nine-byte sensor response frames from a stream of UART bytes and
// time ticks and reports the ppm value of every good frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o): one request per cycle, cmd_i = 0
//   carries rx_byte_i, cmd_i = 1 is one time tick.
//   Output channel (out_valid_o/out_ready_i): one result per frame that has
//   a good header (0xFF, 0x86) and checksum: ppm_o and significant_change_o.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 change threshold,
//   index 1 gap timeout in ticks; other indexes are ignored. Always ready.
//   Throughput: one request per cycle. A result is visible in the cycle
//   after the ninth byte of its frame is accepted.
//   The parser state updates in the accept cycle; results go through a
//   two-entry queue, so requests keep flowing while one result waits.
//   When the receiver stalls with two results pending, in_ready_o drops
//   until a result is taken.
//   Reset clears the frame state, the last significant ppm value and the queue,
//   and sets threshold 1 and timeout 10.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_frame_receiver_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [15:0]                        ppm_o,
  output logic                               significant_change_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [csfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);
  import csfr_pkg::*;

  csfr_cfg_t    cfg_q;
  logic         fifo_full;
  logic         item_valid;
  logic         res_valid;
  csfr_result_t res;
  csfr_result_t out_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_full;
  assign item_valid  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_threshold  <= ThresholdReset;
      cfg_q.gap_timeout_ticks <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegChangeThreshold: cfg_q.change_threshold  <= cfg_data_i;
        RegGapTimeout:      cfg_q.gap_timeout_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .cmd_i        (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  csfr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  assign ppm_o                = out_data.ppm;
  assign significant_change_o = out_data.significant_change;

endmodule

`default_nettype wire
